// File: rtl/packet_buffer_start_time_unit_macros.svh
// Assertion macros shared by the packet buffer start time RTL.
`ifndef PACKET_BUFFER_START_TIME_UNIT_MACROS_SVH
`define PACKET_BUFFER_START_TIME_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on aclk, off during reset.
`define PBST_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pbst assertion failed");
// Next-cycle implication, clocked on aclk, off during reset.
`define PBST_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pbst assertion failed");
`else
`define PBST_ASSERT(label, ante, cons)
`define PBST_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/pbst_pkg.sv
// Package: sizes, register reset value and shared arithmetic unit op codes.
package pbst_pkg;

    localparam int BUF_DEPTH = 64;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int TIME_W    = 32;
    localparam int DUR_W     = 16;
    localparam int CFG_W     = 7;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // shared unit operations
    localparam logic ALU_OP_LE  = 1'b0;  // flag = a <= b, result = a
    localparam logic ALU_OP_ADD = 1'b1;  // result = a + b, saturating

    typedef logic [TIME_W-1:0] time_t;

endpackage

// File: rtl/packet_buffer_start_time_unit.sv
// Flow: IDLE accepts a request, CHECK retires finished head entries, MAXS picks
// the start, ADD pushes the finish time and RESULT hands the result over; a drop
// goes from CHECK to RESULT. One request at a time; one shared compare/add unit, one RAM read per retire.
// The result register lets the next request in while a result waits.
// Reset (aresetn low, synchronous): queue empty, last finish 0, buffer_size 64;
// the finish time RAM is not cleared and needs no clearing pass.
`include "packet_buffer_start_time_unit_macros.svh"
module packet_buffer_start_time_unit
    import pbst_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    // packet request
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_arrival_time,
    input  logic [DUR_W-1:0]  s_duration,
    // result
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_dropped,
    output logic [31:0]       m_start_time
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for a request
    localparam logic [2:0] ST_CHECK  = 3'd1;  // retire head while finish <= arrival
    localparam logic [2:0] ST_MAXS   = 3'd2;  // start = max(arrival, last finish)
    localparam logic [2:0] ST_ADD    = 3'd3;  // finish = start + duration, push
    localparam logic [2:0] ST_RESULT = 3'd4;  // hand result to output register

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  size_reg;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    time_t             last_reg, last_next;
    time_t             arr_reg, arr_next;
    logic [DUR_W-1:0]  dur_reg, dur_next;
    time_t             start_reg, start_next;
    logic              drop_reg, drop_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_dropped_reg, m_dropped_next;
    time_t             m_start_reg, m_start_next;

    logic [CNT_W-1:0]  cap;
    logic [CNT_W:0]    tail_sum;
    logic [ADDR_W-1:0] tail;
    logic              ram_we;
    time_t             ram_rdata;

    logic              alu_op;
    time_t             alu_a, alu_b, alu_result;
    logic              alu_le;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_dropped    = m_dropped_reg;
    assign m_start_time = m_start_reg;

    // capacity saturates at the physical depth
    assign cap = (32'(size_reg) > BUF_DEPTH) ? CNT_W'(BUF_DEPTH) : CNT_W'(size_reg);

    // tail = (head + count) mod depth
    assign tail_sum = (CNT_W + 1)'(head_reg) + (CNT_W + 1)'(count_reg);
    assign tail = (32'(tail_sum) >= BUF_DEPTH) ?
                  ADDR_W'(tail_sum - (CNT_W + 1)'(BUF_DEPTH)) : ADDR_W'(tail_sum);

    assign ram_we = (state_reg == ST_ADD);

    // Read address follows next head, so in CHECK the read data is the head entry.
    // A push is written in ADD, before the read for the next CHECK, so data is fresh.
    pbst_ram #(
        .WIDTH (TIME_W),
        .DEPTH (BUF_DEPTH)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail),
        .wdata (alu_result),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    // operand select for the shared unit
    always_comb begin
        case (state_reg)
            ST_CHECK: begin
                alu_op = ALU_OP_LE;
                alu_a  = ram_rdata;
                alu_b  = arr_reg;
            end
            ST_MAXS: begin
                alu_op = ALU_OP_LE;
                alu_a  = arr_reg;
                alu_b  = last_reg;
            end
            ST_ADD: begin
                alu_op = ALU_OP_ADD;
                alu_a  = start_reg;
                alu_b  = TIME_W'(dur_reg);
            end
            default: begin
                alu_op = ALU_OP_LE;
                alu_a  = arr_reg;
                alu_b  = last_reg;
            end
        endcase
    end

    pbst_alu u_alu (
        .op      (alu_op),
        .a       (alu_a),
        .b       (alu_b),
        .result  (alu_result),
        .le_flag (alu_le)
    );

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        arr_next       = arr_reg;
        dur_next       = dur_reg;
        start_next     = start_reg;
        drop_next      = drop_reg;
        m_valid_next   = m_valid_reg;
        m_dropped_next = m_dropped_reg;
        m_start_next   = m_start_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    arr_next   = s_arrival_time;
                    dur_next   = s_duration;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if ((count_reg != '0) && alu_le) begin
                    // retire the head entry
                    head_next  = (32'(head_reg) == BUF_DEPTH - 1) ?
                                 '0 : head_reg + ADDR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                end else if (count_reg >= cap) begin
                    drop_next  = 1'b1;
                    start_next = '0;
                    state_next = ST_RESULT;
                end else begin
                    drop_next  = 1'b0;
                    state_next = ST_MAXS;
                end
            end
            ST_MAXS: begin
                start_next = alu_le ? last_reg : arr_reg;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                count_next = count_reg + CNT_W'(1);
                last_next  = alu_result;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_dropped_next = drop_reg;
                    m_start_next   = start_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= CFG_RESET;
            head_reg    <= '0;
            count_reg   <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        arr_reg       <= arr_next;
        dur_reg       <= dur_next;
        start_reg     <= start_next;
        drop_reg      <= drop_next;
        m_dropped_reg <= m_dropped_next;
        m_start_reg   <= m_start_next;
    end

    `PBST_ASSERT(a_count_bound, 1'b1, 32'(count_reg) <= BUF_DEPTH)
    `PBST_ASSERT_NXT(a_count_quiet, (state_reg == ST_IDLE) || (state_reg == ST_MAXS) || (state_reg == ST_RESULT), $stable(count_reg))
    `PBST_ASSERT(a_start_late, (state_reg == ST_RESULT) && !drop_reg, start_reg >= arr_reg)
    `PBST_ASSERT(a_drop_full, (state_reg == ST_RESULT) && drop_reg, count_reg >= cap)
    `PBST_ASSERT(a_push_room, state_reg == ST_ADD, count_reg < cap)

endmodule

// File: rtl/pbst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module pbst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/pbst_alu.sv
// Shared time unit: one 32-bit compare or one saturating add per cycle.
module pbst_alu
    import pbst_pkg::*;
(
    input  logic  op,
    input  time_t a,
    input  time_t b,
    output time_t result,
    output logic  le_flag
);

    logic [TIME_W:0] sum;

    always_comb begin
        sum     = {1'b0, a} + {1'b0, b};
        le_flag = (a <= b);
        case (op)
            ALU_OP_LE:  result = a;
            ALU_OP_ADD: result = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            default:    result = a;
        endcase
    end

endmodule

// File: sim/packet_buffer_start_time_unit_test.sv
// Self-checking testbench for the packet buffer start time unit.
module packet_buffer_start_time_unit_test
    import pbst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 8;                 // quiet cycles before a buffer size write
    localparam int TAIL_CYCLES  = 4 + BUF_DEPTH + 8; // worst latency: full retire sweep
    localparam int TIMEOUT_NS   = 5_000_000;         // far beyond the slowest legal run

    // what the driver does next: send a packet, write the buffer size,
    // wait for the pipe to empty, or switch the idling mix
    typedef enum logic [1:0] {
        STEP_PACKET,
        STEP_CONFIG,
        STEP_DRAIN,
        STEP_PHASE
    } step_kind_e;

    typedef struct {
        step_kind_e       kind;
        time_t            arrival;
        logic [DUR_W-1:0] dur;
        logic [CFG_W-1:0] size;
        int unsigned      idle;
        int unsigned      stall;
    } step_t;

    typedef struct packed {
        logic  dropped;
        time_t start_time;
    } start_result_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              cfg_valid      = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data       = '0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [31:0]       s_arrival_time = '0;
    logic [DUR_W-1:0]  s_duration     = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic              m_dropped;
    logic [31:0]       m_start_time;

    step_t         plan[$];          // pending requests, config writes and pauses
    start_result_t due_results[$];   // start times owed by the block, oldest first

    int unsigned idle_pct   = 0;     // sender: chance in 100 of a gap cycle
    int unsigned stall_pct  = 0;     // receiver: chance in 100 of holding m_ready low
    int unsigned settle_cnt = 0;
    time_t       arrival_clock = '0; // running arrival time of the generated traffic

    int unsigned error_count   = 0;
    int unsigned checked_count = 0;
    int unsigned drop_count    = 0;
    int unsigned size_writes   = 0;

    // mirror of the block: ring of finish times plus the scheduling state
    time_t             finish_ring[BUF_DEPTH];
    logic [ADDR_W-1:0] ring_head;
    logic [CNT_W-1:0]  ring_held;
    time_t             last_finish;
    logic [CFG_W-1:0]  slot_limit;

    always #(HALF_PERIOD) aclk = ~aclk;

    packet_buffer_start_time_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_arrival_time (s_arrival_time),
        .s_duration     (s_duration),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dropped      (m_dropped),
        .m_start_time   (m_start_time)
    );

    // Schedule one packet: retire finished entries, then drop or queue it.
    function automatic start_result_t schedule_packet(time_t arrival, logic [DUR_W-1:0] dur);
        start_result_t     r;
        logic [CNT_W-1:0]  cap;
        logic [ADDR_W-1:0] tail_idx;
        logic [TIME_W:0]   sum;
        time_t             t_start;
        time_t             t_finish;
        cap = (slot_limit > BUF_DEPTH) ? CNT_W'(BUF_DEPTH) : CNT_W'(slot_limit);
        // retire is inclusive: a finish equal to the arrival frees its slot
        while (ring_held > 0 && finish_ring[ring_head] <= arrival) begin
            ring_head = ring_head + ADDR_W'(1);
            ring_held = ring_held - CNT_W'(1);
        end
        if (ring_held >= cap) begin
            r.dropped    = 1'b1;
            r.start_time = '0;
            return r;
        end
        t_start  = (arrival > last_finish) ? arrival : last_finish;
        sum      = {1'b0, t_start} + (TIME_W + 1)'(dur);
        t_finish = sum[TIME_W] ? '1 : sum[TIME_W-1:0];  // saturate at top of time range
        tail_idx = ring_head + ring_held[ADDR_W-1:0];
        finish_ring[tail_idx] = t_finish;
        ring_held   = ring_held + CNT_W'(1);
        last_finish = t_finish;
        r.dropped    = 1'b0;
        r.start_time = t_start;
        return r;
    endfunction

    task automatic plan_packet(time_t arrival, logic [DUR_W-1:0] dur);
        step_t s;
        s         = '{kind: STEP_PACKET, arrival: arrival, dur: dur, size: '0, idle: 0, stall: 0};
        plan.push_back(s);
    endtask

    // Pause until every result is back, write the size, then switch idling.
    task automatic plan_setting(logic [CFG_W-1:0] size, int unsigned idle, int unsigned stall);
        step_t s;
        s = '{kind: STEP_DRAIN, arrival: '0, dur: '0, size: '0, idle: 0, stall: 0};
        plan.push_back(s);
        s.kind = STEP_CONFIG;
        s.size = size;
        plan.push_back(s);
        s.kind  = STEP_PHASE;
        s.idle  = idle;
        s.stall = stall;
        plan.push_back(s);
    endtask

    // Mostly in-order traffic; rare long gaps flush the buffer in one sweep,
    // rare out-of-order arrivals exercise the no-error path.
    task automatic plan_random_burst(int count, int unsigned gap_max, int unsigned dur_max);
        int unsigned      roll;
        time_t            arr;
        logic [DUR_W-1:0] dur;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 4)
                arrival_clock = arrival_clock + $urandom_range(200000, 20000);
            else
                arrival_clock = arrival_clock + $urandom_range(gap_max);
            arr = arrival_clock;
            if (roll >= 96)
                arr = (arrival_clock > 3000) ? arrival_clock - $urandom_range(3000) : '0;
            roll = $urandom_range(99);
            if (roll < 5)
                dur = '0;
            else if (roll < 8)
                dur = '1;
            else
                dur = DUR_W'($urandom_range(dur_max));
            plan_packet(arr, dur);
        end
    endtask

    // Driver: launches the next step only when no request is stuck in flight.
    always @(posedge aclk) begin : driver
        step_t step;
        logic  launch_pkt;
        logic  launch_cfg;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            cfg_valid  <= 1'b0;
            settle_cnt <= 0;
        end else if (!(s_valid && !s_ready) && !(cfg_valid && !cfg_ready)) begin
            launch_pkt = 1'b0;
            launch_cfg = 1'b0;
            if (plan.size() > 0) begin
                step = plan[0];
                case (step.kind)
                    STEP_PACKET: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            launch_pkt = 1'b1;
                            void'(plan.pop_front());
                        end
                    end
                    STEP_CONFIG: begin
                        launch_cfg = 1'b1;
                        void'(plan.pop_front());
                    end
                    STEP_DRAIN: begin
                        // sender holds off until the block has nothing in flight
                        if (!s_valid && !cfg_valid && due_results.size() == 0) begin
                            if (settle_cnt >= SETTLE - 1) begin
                                settle_cnt <= 0;
                                void'(plan.pop_front());
                            end else begin
                                settle_cnt <= settle_cnt + 1;
                            end
                        end else begin
                            settle_cnt <= 0;
                        end
                    end
                    STEP_PHASE: begin
                        idle_pct  <= step.idle;
                        stall_pct <= step.stall;
                        void'(plan.pop_front());
                    end
                    default: ;
                endcase
            end
            s_valid   <= launch_pkt;
            cfg_valid <= launch_cfg;
            if (launch_pkt) begin
                s_arrival_time <= step.arrival;
                s_duration     <= step.dur;
            end
            if (launch_cfg)
                cfg_data <= step.size;
        end
    end

    // Monitor: tracks config writes and accepted requests into the mirror,
    // and checks each result against the oldest owed start time.
    always @(posedge aclk) begin : monitor
        start_result_t want;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            ring_head   = '0;
            ring_held   = '0;
            last_finish = '0;
            slot_limit  = CFG_RESET;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
            if (cfg_valid && cfg_ready) begin
                slot_limit  = cfg_data;
                size_writes = size_writes + 1;
            end
            if (s_valid && s_ready)
                due_results.push_back(schedule_packet(s_arrival_time, s_duration));
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with nothing owed: dropped %0b start %0d",
                             $time, m_dropped, m_start_time);
                    error_count = error_count + 1;
                end else begin
                    want = due_results.pop_front();
                    if (m_dropped !== want.dropped) begin
                        $display("%0t: dropped expected %0b actual %0b",
                                 $time, want.dropped, m_dropped);
                        error_count = error_count + 1;
                    end
                    if (m_start_time !== want.start_time) begin
                        $display("%0t: start_time expected %0d actual %0d",
                                 $time, want.start_time, m_start_time);
                        error_count = error_count + 1;
                    end
                    checked_count = checked_count + 1;
                    if (want.dropped)
                        drop_count = drop_count + 1;
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        // directed, reset size of 64: zero and max duration, inclusive retire,
        // out-of-order arrival, long gap that empties the buffer
        plan_packet(32'd0, 16'd0);
        plan_packet(32'd0, 16'hFFFF);
        plan_packet(32'd10, 16'd5);
        plan_packet(32'd5, 16'd1);
        plan_packet(32'd200000, 16'd0);
        plan_packet(32'd200000, 16'd7);
        // size zero: everything dropped, all bits of the register low
        plan_setting(7'd0, 0, 0);
        plan_packet(32'd300000, 16'd3);
        plan_packet(32'd300001, 16'd3);
        // size one: drop while busy, accept once the finish time is reached
        plan_setting(7'd1, 0, 0);
        plan_packet(32'd400000, 16'd100);
        plan_packet(32'd400050, 16'd10);
        plan_packet(32'd400100, 16'd10);
        // size above depth, all register bits high: capacity clamps at depth
        plan_setting(7'd127, 0, 0);
        plan_packet(32'd400200, 16'd1000);
        plan_packet(32'd400201, 16'd1000);
        plan_packet(32'd400202, 16'd1000);
        arrival_clock = 32'd500000;

        // random phases, sizes and idling mixes varied
        plan_setting(7'd4, 0, 0);
        plan_random_burst(60, 100, 300);
        plan_setting(7'd64, 80, 0);
        plan_random_burst(60, 20, 1500);
        plan_setting(7'd1, 0, 80);
        plan_random_burst(60, 200, 300);
        plan_setting(7'd127, 31, 31);
        plan_random_burst(60, 10, 2000);
        plan_setting(7'd0, 0, 0);
        plan_random_burst(20, 50, 500);
        plan_setting(CFG_W'($urandom_range(127, 1)), 80, 80);
        plan_random_burst(60, 40, 1200);
        plan_setting(7'd65, 0, 0);
        plan_random_burst(60, 30, 1000);
        plan_setting(CFG_W'($urandom_range(127, 1)), 31, 31);
        plan_random_burst(60, 60, 800);

        // top of the time range last: saturated finish times never retire
        // except by an arrival at the maximum, so nothing may follow them
        plan_setting(7'd64, 0, 0);
        plan_packet(32'hFFFF_FF00, 16'hFFFF);
        plan_packet(32'hFFFF_FF10, 16'd5);
        plan_packet(32'hFFFF_FFFE, 16'd0);
        plan_packet(32'hFFFF_FFFF, 16'hFFFF);
        plan_setting(7'd1, 0, 0);
        plan_packet(32'hFFFF_FFFF, 16'd0);
        plan_packet(32'hFFFF_FFF0, 16'd1);
        plan_packet(32'hFFFF_FFFF, 16'd1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (plan.size() != 0 || s_valid || cfg_valid || due_results.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Checked %0d packet start times (%0d dropped) over %0d buffer size writes.",
                 checked_count, drop_count, size_writes);
        $display("Sizes from zero to above depth; in-order, out-of-order and saturating times.");
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pbst_pkg.sv
rtl/pbst_ram.sv
rtl/pbst_alu.sv
rtl/packet_buffer_start_time_unit.sv
sim/packet_buffer_start_time_unit_test.sv
